// ----- design/vsrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vsrm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 16;
    localparam int SUM_BITS = COUNT_BITS + VALUE_BITS + 1;
    localparam int TAG_BITS = 8;
    localparam int SENSOR_BITS = 3;
    localparam int PRESENT_BITS = 3;
    localparam int RKIND_BITS = 2;
    localparam int NUM_TYPES = 4;
    localparam int TYPE_BITS = 2;
    localparam int REG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = VALUE_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int IN_DATA_BITS = ((TAG_BITS + 2 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 1 + COUNT_BITS + 3 * VALUE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = RKIND_BITS + SENSOR_BITS;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_PATIENT_TAG = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_THRESH_PRESENT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TEMP_MIN = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_TEMP_MAX = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_OXY_MIN = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_OXY_MAX = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_BP_SUM_MIN = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_BP_SUM_MAX = 3'd7;

    // sensor kinds
    localparam logic [SENSOR_BITS-1:0] SENSOR_TEMP = 3'd0;
    localparam logic [SENSOR_BITS-1:0] SENSOR_OXY = 3'd1;
    localparam logic [SENSOR_BITS-1:0] SENSOR_BP = 3'd2;
    localparam logic [SENSOR_BITS-1:0] SENSOR_ECG = 3'd3;

    // present bits
    localparam int PRESENT_TEMP = 0;
    localparam int PRESENT_OXY = 1;
    localparam int PRESENT_BP = 2;

    // result kinds
    localparam logic [RKIND_BITS-1:0] RK_VERDICT = 2'd0;
    localparam logic [RKIND_BITS-1:0] RK_SUMMARY = 2'd1;
    localparam logic [RKIND_BITS-1:0] RK_NOT_FOUND = 2'd2;
    localparam logic [RKIND_BITS-1:0] RK_IGNORED = 2'd3;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DIV,
        BK_EMIT,
        BK_NF
    } back_state_t;

    typedef struct packed {
        logic                         ignored;
        logic [SENSOR_BITS-1:0]       kind;
        logic                         anom;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } queue_entry_t;

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [SUM_BITS-1:0]   dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                         done;
        logic signed [VALUE_BITS-1:0] quot;
    } div_resp_t;

    typedef struct packed {
        logic [RKIND_BITS-1:0]        kind;
        logic [SENSOR_BITS-1:0]       sensor;
        logic                         anom;
        logic [COUNT_BITS-1:0]        count;
        logic signed [VALUE_BITS-1:0] min_v;
        logic signed [VALUE_BITS-1:0] max_v;
        logic signed [VALUE_BITS-1:0] mean_v;
        logic                         final_r;
    } result_t;

    // summaries go out as temperature, pressure, oximetry, ECG
    function automatic logic [TYPE_BITS-1:0] summary_type(input logic [TYPE_BITS-1:0] idx);
        logic [TYPE_BITS-1:0] t;
        case (idx)
            2'd0:    t = 2'd0;
            2'd1:    t = 2'd2;
            2'd2:    t = 2'd1;
            default: t = 2'd3;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- design/vsrm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vsrm_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [vsrm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    input  wire logic [vsrm_pkg::SENSOR_BITS-1:0]    s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [vsrm_pkg::REG_IDX_BITS-1:0]   cfg_addr,
    input  wire logic [vsrm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output vsrm_pkg::queue_entry_t                   q_entry
);
    import vsrm_pkg::*;

    logic [TAG_BITS-1:0]            patient_tag_reg;
    logic [PRESENT_BITS-1:0]        present_reg;
    logic signed [VALUE_BITS-1:0]   temp_min_reg;
    logic signed [VALUE_BITS-1:0]   temp_max_reg;
    logic signed [VALUE_BITS-1:0]   oxy_min_reg;
    logic signed [VALUE_BITS-1:0]   oxy_max_reg;
    logic signed [VALUE_BITS:0]     bp_min_reg;
    logic signed [VALUE_BITS:0]     bp_max_reg;

    logic [TAG_BITS-1:0]            tag;
    logic [SENSOR_BITS-1:0]         kind;
    logic signed [VALUE_BITS-1:0]   val_a;
    logic signed [VALUE_BITS-1:0]   val_b;
    logic signed [VALUE_BITS:0]     sum_ab;
    logic                           anom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patient_tag_reg <= '0;
            present_reg     <= '0;
            temp_min_reg    <= '0;
            temp_max_reg    <= '0;
            oxy_min_reg     <= '0;
            oxy_max_reg     <= '0;
            bp_min_reg      <= '0;
            bp_max_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PATIENT_TAG:    patient_tag_reg <= cfg_wdata[TAG_BITS-1:0];
                REG_THRESH_PRESENT: present_reg     <= cfg_wdata[PRESENT_BITS-1:0];
                REG_TEMP_MIN:       temp_min_reg    <= cfg_wdata[VALUE_BITS-1:0];
                REG_TEMP_MAX:       temp_max_reg    <= cfg_wdata[VALUE_BITS-1:0];
                REG_OXY_MIN:        oxy_min_reg     <= cfg_wdata[VALUE_BITS-1:0];
                REG_OXY_MAX:        oxy_max_reg     <= cfg_wdata[VALUE_BITS-1:0];
                REG_BP_SUM_MIN:     bp_min_reg      <= cfg_wdata[VALUE_BITS:0];
                REG_BP_SUM_MAX:     bp_max_reg      <= cfg_wdata[VALUE_BITS:0];
                default:            ;
            endcase
        end
    end

    assign tag    = s_axis_tdata[TAG_BITS-1:0];
    assign val_a  = s_axis_tdata[TAG_BITS +: VALUE_BITS];
    assign val_b  = s_axis_tdata[TAG_BITS+VALUE_BITS +: VALUE_BITS];
    assign kind   = s_axis_tuser;
    assign sum_ab = {val_a[VALUE_BITS-1], val_a} + {val_b[VALUE_BITS-1], val_b};

    always_comb
    begin
        case (kind)
            SENSOR_TEMP: anom = present_reg[PRESENT_TEMP]
                                && (val_a < temp_min_reg || val_a > temp_max_reg);
            SENSOR_OXY:  anom = present_reg[PRESENT_OXY]
                                && (val_a < oxy_min_reg || val_a > oxy_max_reg);
            SENSOR_BP:   anom = present_reg[PRESENT_BP]
                                && (sum_ab < bp_min_reg || sum_ab > bp_max_reg);
            default:     anom = 1'b0;
        endcase
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_entry.ignored = (tag != patient_tag_reg) || (kind > SENSOR_ECG);
        q_entry.kind    = kind;
        q_entry.anom    = anom;
        // pressure statistic: floor of half the sum
        q_entry.value   = (kind == SENSOR_BP) ? sum_ab[VALUE_BITS:1] : val_a;
        q_entry.last    = s_axis_tlast;
    end

endmodule

`default_nettype wire

// ----- design/vsrm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vsrm_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire vsrm_pkg::queue_entry_t  push_entry,
    output logic                         full,
    input  wire logic                    pop,
    output vsrm_pkg::queue_entry_t       pop_entry,
    output logic                         empty
);
    import vsrm_pkg::*;

    queue_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   fill_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/vsrm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle, sign applied at the end
module vsrm_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vsrm_pkg::div_req_t  req,
    output vsrm_pkg::div_resp_t      resp
);
    import vsrm_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [SUM_BITS-1:0]     quot_reg;
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [COUNT_BITS-1:0]   divisor_reg;
    logic                    neg_reg;

    logic [COUNT_BITS:0]     shifted;
    logic                    ge;
    logic [COUNT_BITS:0]     diff;
    logic [SUM_BITS-1:0]     signed_q;

    assign shifted  = {rem_reg, quot_reg[SUM_BITS-1]};
    assign ge       = shifted >= {1'b0, divisor_reg};
    assign diff     = shifted - {1'b0, divisor_reg};
    assign signed_q = neg_reg ? (~quot_reg + 1'b1) : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_BITS'(SUM_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            neg_reg     <= req.neg;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SUM_BITS-2:0], ge};
            rem_reg  <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
        end
    end

    assign resp.done = done_reg;
    assign resp.quot = signed_q[VALUE_BITS-1:0];

endmodule

`default_nettype wire

// ----- design/vsrm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vsrm_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_empty,
    input  wire vsrm_pkg::queue_entry_t  q_entry,
    output logic                         q_pop,
    output vsrm_pkg::div_req_t           div_req,
    input  wire vsrm_pkg::div_resp_t     div_resp,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output vsrm_pkg::result_t            out_res
);
    import vsrm_pkg::*;

    back_state_t                  state_reg, state_next;
    logic [TYPE_BITS-1:0]         idx_reg, idx_next;
    logic [COUNT_BITS-1:0]        cnt_reg [NUM_TYPES];
    logic signed [VALUE_BITS-1:0] min_reg [NUM_TYPES];
    logic signed [VALUE_BITS-1:0] max_reg [NUM_TYPES];
    logic signed [SUM_BITS-1:0]   sum_reg [NUM_TYPES];
    logic                         out_valid_reg;
    result_t                      out_reg;

    logic                         slot_free;
    logic [TYPE_BITS-1:0]         rd_idx;
    logic [COUNT_BITS-1:0]        rd_cnt;
    logic signed [VALUE_BITS-1:0] rd_min;
    logic signed [VALUE_BITS-1:0] rd_max;
    logic signed [SUM_BITS-1:0]   rd_sum;
    logic [NUM_TYPES-1:0]         nz;
    logic                         any_nz;
    logic                         later_nz;
    logic signed [SUM_BITS-1:0]   v_ext;

    logic                         load;
    result_t                      res;
    logic                         upd;
    logic                         clr;

    assign slot_free = !out_valid_reg || out_ready;
    assign rd_idx    = (state_reg == BK_IDLE) ? q_entry.kind[TYPE_BITS-1:0]
                       : summary_type(idx_reg);
    assign rd_cnt    = cnt_reg[rd_idx];
    assign rd_min    = min_reg[rd_idx];
    assign rd_max    = max_reg[rd_idx];
    assign rd_sum    = sum_reg[rd_idx];
    assign v_ext     = {{(SUM_BITS-VALUE_BITS){q_entry.value[VALUE_BITS-1]}}, q_entry.value};

    always_comb
    begin
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            nz[i] = (cnt_reg[i] != '0);
        end
    end
    assign any_nz = |nz;

    // any type after the current one in summary order still to report
    always_comb
    begin
        later_nz = 1'b0;
        for (int j = 0; j < NUM_TYPES; j++)
        begin
            if (TYPE_BITS'(j) > idx_reg && nz[summary_type(TYPE_BITS'(j))])
            begin
                later_nz = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && slot_free && q_entry.last)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (!any_nz)
                begin
                    state_next = BK_NF;
                end
                else if (rd_cnt != '0)
                begin
                    state_next = BK_DIV;
                end
                else if (idx_reg == TYPE_BITS'(NUM_TYPES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                if (div_resp.done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = later_nz ? BK_SCAN : BK_IDLE;
                end
            end
            BK_NF:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop            = 1'b0;
        load             = 1'b0;
        upd              = 1'b0;
        clr              = 1'b0;
        idx_next         = idx_reg;
        res              = '0;
        div_req.start    = 1'b0;
        div_req.neg      = rd_sum[SUM_BITS-1];
        div_req.dividend = rd_sum[SUM_BITS-1] ? SUM_BITS'(-rd_sum) : SUM_BITS'(rd_sum);
        div_req.divisor  = rd_cnt;
        case (state_reg)
            BK_IDLE:
            begin
                idx_next    = '0;
                q_pop       = !q_empty && slot_free;
                load        = q_pop;
                upd         = q_pop && !q_entry.ignored;
                res.kind    = q_entry.ignored ? RK_IGNORED : RK_VERDICT;
                res.sensor  = q_entry.kind;
                res.anom    = !q_entry.ignored && q_entry.anom;
                res.final_r = !q_entry.last;
            end
            BK_SCAN:
            begin
                div_req.start = any_nz && (rd_cnt != '0);
                if (any_nz && rd_cnt == '0 && idx_reg != TYPE_BITS'(NUM_TYPES - 1))
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_DIV:
            begin
            end
            BK_EMIT:
            begin
                load        = slot_free;
                res.kind    = RK_SUMMARY;
                res.sensor  = SENSOR_BITS'(summary_type(idx_reg));
                res.count   = rd_cnt;
                res.min_v   = rd_min;
                res.max_v   = rd_max;
                res.mean_v  = div_resp.quot;
                res.final_r = !later_nz;
                if (slot_free)
                begin
                    if (later_nz)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        clr = 1'b1;
                    end
                end
            end
            BK_NF:
            begin
                load        = slot_free;
                res.kind    = RK_NOT_FOUND;
                res.final_r = 1'b1;
                clr         = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                cnt_reg[i] <= '0;
                min_reg[i] <= '0;
                max_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clr)
            begin
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    cnt_reg[i] <= '0;
                    min_reg[i] <= '0;
                    max_reg[i] <= '0;
                    sum_reg[i] <= '0;
                end
            end
            else if (upd)
            begin
                if (rd_cnt == '0 || q_entry.value < rd_min)
                begin
                    min_reg[rd_idx] <= q_entry.value;
                end
                if (rd_cnt == '0 || q_entry.value > rd_max)
                begin
                    max_reg[rd_idx] <= q_entry.value;
                end
                // saturated count freezes count and sum
                if (rd_cnt != '1)
                begin
                    cnt_reg[rd_idx] <= rd_cnt + 1'b1;
                    sum_reg[rd_idx] <= rd_sum + v_ext;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

// ----- design/vital_sign_range_monitor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      one sensor reading, tlast = last reading
// m_axis    out  m_axis_tvalid/tready      verdict, ignored, summary or not-found item
// cfg       in   cfg_we (no wait)          register index and write data
//
// Front takes one reading per cycle while the two-entry queue has room.
// Back presents the verdict of a reading in the cycle after it takes the reading from the queue.
// A last reading adds one summary per active type (a not-found item if none),
// each behind the serial divider that computes the mean.
// Reset clears configuration, statistics, queue and output valid flag.
// Output stalls back up through the queue to s_axis_tready.
module vital_sign_range_monitor_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // reading_patient, value_a, value_b
    input  wire logic [vsrm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // sensor_kind
    input  wire logic [vsrm_pkg::SENSOR_BITS-1:0]    s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // anomalous, reading_count, min_value, max_value, mean_value
    output logic [vsrm_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,
    // result_kind, result_sensor
    output logic [vsrm_pkg::OUT_USER_BITS-1:0]       m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [vsrm_pkg::REG_IDX_BITS-1:0]   cfg_addr,
    input  wire logic [vsrm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import vsrm_pkg::*;

    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    queue_entry_t push_entry;
    queue_entry_t pop_entry;
    div_req_t     div_req;
    div_resp_t    div_resp;
    result_t      res;

    vsrm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    vsrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    vsrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    vsrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_resp  (div_resp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({res.mean_v, res.max_v, res.min_v, res.count, res.anom});
    assign m_axis_tuser = {res.sensor, res.kind};
    assign m_axis_tlast = res.final_r;

endmodule

`default_nettype wire
